>>> hdl/lorenz_euler_step_macros.svh
// Assertion macros used by the Lorenz step checker.
`ifndef LORENZ_EULER_STEP_MACROS_SVH
`define LORENZ_EULER_STEP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define LRZ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LRZ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/lrz_pkg.sv
// Shared types and constants of the Lorenz Euler step block.
package lrz_pkg;

  localparam int Q_W       = 32;  // Q16.16 word
  localparam int RAD_W     = 31;  // radius, unsigned Q15.16
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z = 2'd2;

  // Start x coordinate after reset (0.1 in Q16.16)
  localparam logic signed [Q_W-1:0] START_X_RST = 32'sd6554;

  typedef struct packed {
    logic signed [Q_W-1:0] step_size;
    logic signed [Q_W-1:0] sigma;
    logic signed [Q_W-1:0] rho;
    logic signed [Q_W-1:0] beta;
  } in_item_t;

  typedef struct packed {
    logic signed [Q_W-1:0] new_x;
    logic signed [Q_W-1:0] new_y;
    logic signed [Q_W-1:0] new_z;
    logic [RAD_W-1:0]      radius;
  } out_item_t;

endpackage

>>> hdl/lrz_ifs.sv
// Valid/ready channel interfaces for the input and result items.
interface lrz_in_if;
  logic               valid;
  logic               ready;
  lrz_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrz_out_if;
  logic               valid;
  logic               ready;
  lrz_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/lrz_isqrt.sv
// Bit-serial integer square root of a 64-bit value, two radicand bits per cycle.
module lrz_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic        done,
  output logic [31:0] root
);

  localparam int REM_W = 36;

  logic [63:0]      rad_r;
  logic [REM_W-1:0] rem_r;
  logic [31:0]      root_r;
  logic [4:0]       cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down the next two radicand bits and try the next root bit
  assign rem_sh = {rem_r[REM_W-3:0], rad_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  // Control: count 32 digit steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd31;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: restoring square root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[61:0], 2'b00};
      if (fits) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

>>> hdl/lorenz_euler_step.sv
// Lorenz attractor, one forward Euler step per transfer, signed Q16.16.
// Each input transfer carries h, sigma, rho and beta; the block advances its
// stored point (x, y, z) by one Euler step and returns the new point and its
// distance from the origin. Products and sums saturate to 32 bits, the radius
// to 31 bits; products round toward minus infinity. An item runs through the
// single shared 33x33 multiplier and saturating adder under the step sequencer,
// then the two-bits-per-cycle square root (32 digit steps and its done cycle),
// and then the result register is loaded. The input takes no new item until the
// sequencer is back in idle, so items never overlap; a result register that is
// still full holds the sequencer in its last step until it drains.
// The input is not ready while an item is in progress; a finished result waits
// in the output register while the next item is taken. Writing start_x,
// start_y or start_z loads that coordinate of the point; write only while idle.
module lorenz_euler_step (
  input  logic                             clk,
  input  logic                             rst_n,
  lrz_in_if.sink                           in_ch,
  lrz_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [lrz_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lrz_pkg::Q_W-1:0]          cfg_wdata
);

  // Sequencer codes
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_S1   = 5'd1;
  localparam logic [4:0] ST_S2   = 5'd2;
  localparam logic [4:0] ST_S3   = 5'd3;
  localparam logic [4:0] ST_S4   = 5'd4;
  localparam logic [4:0] ST_S5   = 5'd5;
  localparam logic [4:0] ST_S6   = 5'd6;
  localparam logic [4:0] ST_S7   = 5'd7;
  localparam logic [4:0] ST_S8   = 5'd8;
  localparam logic [4:0] ST_S9   = 5'd9;
  localparam logic [4:0] ST_S10  = 5'd10;
  localparam logic [4:0] ST_SQ1  = 5'd11;
  localparam logic [4:0] ST_SQ2  = 5'd12;
  localparam logic [4:0] ST_SQ3  = 5'd13;
  localparam logic [4:0] ST_SQ4  = 5'd14;
  localparam logic [4:0] ST_ROOT = 5'd15;
  localparam logic [4:0] ST_DONE = 5'd16;

  localparam logic signed [65:0] PROD_HI = 66'sh7FFFFFFF;
  localparam logic signed [65:0] PROD_LO = -66'sh80000000;
  localparam logic signed [31:0] Q_HI    = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_LO    = 32'sh80000000;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r;

  // Point and per-item operands
  logic signed [31:0] x_r, y_r, z_r;
  logic signed [31:0] h_r, a_r, b_r, c_r;
  logic signed [31:0] t_r, u_r, v_r, w_r, nx_r, ny_r;
  logic signed [65:0] prod_r;
  logic [63:0]        sum_r;
  lrz_pkg::out_item_t out_item_r;

  // Shared unit operands
  logic signed [32:0] mul_a, mul_b;
  logic signed [31:0] add_a, add_b;
  logic               add_sub;
  logic signed [32:0] add_raw;
  logic signed [31:0] add_res;
  logic signed [65:0] prod_sh;
  logic signed [31:0] q_res;
  logic [31:0]        sq_mag;
  logic signed [31:0] sq_src;

  logic        in_take;
  logic        out_free;
  logic        sqrt_done;
  logic [31:0] sqrt_root;
  logic [63:0] sum_fin;
  logic [30:0] radius_sat;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Saturating add or subtract
  assign add_raw = add_sub ? ({add_a[31], add_a} - {add_b[31], add_b})
                           : ({add_a[31], add_a} + {add_b[31], add_b});
  always_comb begin
    if (add_raw[32] == add_raw[31]) begin
      add_res = add_raw[31:0];
    end else if (add_raw[32]) begin
      add_res = Q_LO;
    end else begin
      add_res = Q_HI;
    end
  end

  // Q16.16 product: floor shift, then saturate
  assign prod_sh = prod_r >>> 16;
  always_comb begin
    if (prod_sh > PROD_HI) begin
      q_res = Q_HI;
    end else if (prod_sh < PROD_LO) begin
      q_res = Q_LO;
    end else begin
      q_res = prod_sh[31:0];
    end
  end

  // Magnitude of the coordinate being squared
  always_comb begin
    unique case (state_r)
      ST_SQ2:  sq_src = y_r;
      ST_SQ3:  sq_src = z_r;
      default: sq_src = x_r;
    endcase
  end
  assign sq_mag = sq_src[31] ? (32'd0 - sq_src) : sq_src;

  // Operand selection per sequencer step
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    unique case (state_r) inside
      ST_S1: begin
        add_a = y_r; add_b = x_r; add_sub = 1'b1;
        mul_a = {h_r[31], h_r}; mul_b = {a_r[31], a_r};
      end
      ST_S2: begin
        add_a = b_r; add_b = z_r; add_sub = 1'b1;
        mul_a = {x_r[31], x_r}; mul_b = {y_r[31], y_r};
      end
      ST_S3: begin
        mul_a = {u_r[31], u_r}; mul_b = {t_r[31], t_r};
      end
      ST_S4: begin
        mul_a = {x_r[31], x_r}; mul_b = {v_r[31], v_r};
      end
      ST_S5: begin
        add_a = x_r; add_b = u_r;
        mul_a = {c_r[31], c_r}; mul_b = {z_r[31], z_r};
      end
      ST_S6: begin
        add_a = t_r; add_b = y_r; add_sub = 1'b1;
      end
      ST_S7: begin
        add_a = w_r; add_b = v_r; add_sub = 1'b1;
        mul_a = {h_r[31], h_r}; mul_b = {t_r[31], t_r};
      end
      ST_S8: begin
        mul_a = {h_r[31], h_r}; mul_b = {w_r[31], w_r};
      end
      ST_S9: begin
        add_a = y_r; add_b = t_r;
      end
      ST_S10: begin
        add_a = z_r; add_b = u_r;
      end
      ST_SQ1, ST_SQ2, ST_SQ3: begin
        mul_a = {1'b0, sq_mag}; mul_b = {1'b0, sq_mag};
      end
      default: begin
      end
    endcase
  end

  assign sum_fin = sum_r + prod_r[63:0];

  // Next step of the sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_take) state_nxt = ST_S1;
      ST_S1:   state_nxt = ST_S2;
      ST_S2:   state_nxt = ST_S3;
      ST_S3:   state_nxt = ST_S4;
      ST_S4:   state_nxt = ST_S5;
      ST_S5:   state_nxt = ST_S6;
      ST_S6:   state_nxt = ST_S7;
      ST_S7:   state_nxt = ST_S8;
      ST_S8:   state_nxt = ST_S9;
      ST_S9:   state_nxt = ST_S10;
      ST_S10:  state_nxt = ST_SQ1;
      ST_SQ1:  state_nxt = ST_SQ2;
      ST_SQ2:  state_nxt = ST_SQ3;
      ST_SQ3:  state_nxt = ST_SQ4;
      ST_SQ4:  state_nxt = ST_ROOT;
      ST_ROOT: if (sqrt_done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, point and configuration loads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      x_r         <= lrz_pkg::START_X_RST;
      y_r         <= '0;
      z_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_S10) begin
        x_r <= nx_r;
        y_r <= ny_r;
        z_r <= add_res;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          lrz_pkg::REG_START_X: x_r <= cfg_wdata;
          lrz_pkg::REG_START_Y: y_r <= cfg_wdata;
          lrz_pkg::REG_START_Z: z_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers: operand capture, write-back of the shared unit
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_take) begin
      h_r <= in_ch.data.step_size;
      a_r <= in_ch.data.sigma;
      b_r <= in_ch.data.rho;
      c_r <= in_ch.data.beta;
    end
    case (state_r)
      ST_S1: t_r <= add_res;
      ST_S2: begin
        u_r <= q_res;
        v_r <= add_res;
      end
      ST_S3: w_r <= q_res;
      ST_S4: u_r <= q_res;
      ST_S5: begin
        t_r  <= q_res;
        nx_r <= add_res;
      end
      ST_S6: begin
        v_r <= q_res;
        t_r <= add_res;
      end
      ST_S7: w_r <= add_res;
      ST_S8: t_r <= q_res;
      ST_S9: begin
        u_r  <= q_res;
        ny_r <= add_res;
      end
      ST_SQ2: sum_r <= prod_r[63:0];
      ST_SQ3: sum_r <= sum_fin;
      default: begin
      end
    endcase
    if (state_r == ST_DONE && out_free) begin
      out_item_r.new_x  <= x_r;
      out_item_r.new_y  <= y_r;
      out_item_r.new_z  <= z_r;
      out_item_r.radius <= radius_sat;
    end
  end

  // Square root of the summed squares
  lrz_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == ST_SQ4),
    .value (sum_fin),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign radius_sat = sqrt_root[31] ? 31'h7FFFFFFF : sqrt_root[30:0];

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_item_r;

endmodule

>>> hdl/lrz_checker.sv
// Port-level checker for the Lorenz step block and its bind.
`include "lorenz_euler_step_macros.svh"

module lrz_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // Block goes busy right after taking an item
  `LRZ_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "ready stayed high after an input transfer")

  // No result appears in the cycle right after an input transfer
  `LRZ_ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result raised right after an input transfer")

  // Ready drops only because an item was taken
  `LRZ_ASSERT_SAME(a_ready_drop_on_take, $fell(in_ready), $past(in_valid) && $past(in_ready), "ready dropped without an input transfer")

  // A stalled result stays offered
  `LRZ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result withdrawn while stalled")

endmodule

bind lorenz_euler_step lrz_checker u_lrz_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
